FILE: hdl/line_state_directory_table_unit_macros.svh
// Assertion macros shared by the directory table RTL.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef LINE_STATE_DIRECTORY_TABLE_UNIT_MACROS_SVH
`define LINE_STATE_DIRECTORY_TABLE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define LSD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define LSD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define LSD_ASSERT_SAME(lbl, ante, cons, msg)

`define LSD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: hdl/lsd_pkg.sv
package lsd_pkg;

	localparam int Entries  = 16;
	localparam int LocW     = 32;
	localparam int StateW   = 3;
	localparam int OccW     = 5;
	localparam int IdxW     = (Entries > 1) ? $clog2(Entries) : 1;
	localparam int CntW     = $clog2(Entries + 1);

	typedef enum logic [1:0] {
		CMD_INSERT   = 2'd0,
		CMD_DELETE   = 2'd1,
		CMD_QUERY    = 2'd2,
		CMD_RESERVED = 2'd3
	} lsd_cmd_t;

	typedef logic [LocW-1:0]   lsd_loc_t;
	typedef logic [StateW-1:0] lsd_state_t;
	typedef logic [IdxW-1:0]   lsd_idx_t;
	typedef logic [CntW-1:0]   lsd_cnt_t;
	typedef logic [OccW-1:0]   lsd_occ_t;

	// Outcome of the associative search over all entries.
	typedef struct packed {
		logic       hit;
		lsd_idx_t   hit_idx;
		lsd_state_t old_state;
		logic       free_found;
		lsd_idx_t   free_idx;
	} lsd_lookup_t;

	// Outcome of applying one command to the table.
	typedef struct packed {
		logic     overflow;
		lsd_cnt_t count;
	} lsd_upd_t;

endpackage

FILE: hdl/lsd_lookup.sv
module lsd_lookup (
	input  logic [lsd_pkg::Entries-1:0]                       entry_valid,
	input  logic [lsd_pkg::Entries-1:0][lsd_pkg::LocW-1:0]    entry_loc,
	input  logic [lsd_pkg::Entries-1:0][lsd_pkg::StateW-1:0]  entry_state,
	input  lsd_pkg::lsd_loc_t                                 loc,
	output lsd_pkg::lsd_lookup_t                              result
);
	import lsd_pkg::*;

	logic [Entries-1:0] match;

	// Every entry compares in parallel; the lowest-numbered match and the
	// lowest-numbered free slot win.
	always_comb begin
		result = '0;
		for (int i = Entries - 1; i >= 0; i--) begin
			match[i] = entry_valid[i] && (entry_loc[i] == loc);
			if (match[i]) begin
				result.hit       = 1'b1;
				result.hit_idx   = lsd_idx_t'(i);
				result.old_state = entry_state[i];
			end
			if (!entry_valid[i]) begin
				result.free_found = 1'b1;
				result.free_idx   = lsd_idx_t'(i);
			end
		end
	end

endmodule

FILE: hdl/lsd_store.sv
module lsd_store (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              step,
	input  lsd_pkg::lsd_cmd_t                                 cmd,
	input  lsd_pkg::lsd_loc_t                                 loc,
	input  lsd_pkg::lsd_state_t                               new_state,
	input  lsd_pkg::lsd_lookup_t                              lookup,
	output logic [lsd_pkg::Entries-1:0]                       entry_valid,
	output logic [lsd_pkg::Entries-1:0][lsd_pkg::LocW-1:0]    entry_loc,
	output logic [lsd_pkg::Entries-1:0][lsd_pkg::StateW-1:0]  entry_state,
	output lsd_pkg::lsd_upd_t                                 upd
);
	import lsd_pkg::*;

	logic [Entries-1:0]             valid_q;
	logic [Entries-1:0]             valid_d;
	logic [Entries-1:0][LocW-1:0]   loc_q;
	logic [Entries-1:0][StateW-1:0] state_q;
	lsd_cnt_t                       count_q;
	lsd_cnt_t                       count_d;
	logic                           state_we;
	logic                           loc_we;
	lsd_idx_t                       wr_idx;
	logic                           overflow;

	always_comb begin
		valid_d  = valid_q;
		count_d  = count_q;
		state_we = 1'b0;
		loc_we   = 1'b0;
		wr_idx   = lookup.hit_idx;
		overflow = 1'b0;
		if (step) begin
			unique case (cmd)
				CMD_INSERT: begin
					if (lookup.hit) begin
						state_we = 1'b1;
					end else if (lookup.free_found) begin
						wr_idx           = lookup.free_idx;
						state_we         = 1'b1;
						loc_we           = 1'b1;
						valid_d[wr_idx]  = 1'b1;
						count_d          = count_q + lsd_cnt_t'(1);
					end else begin
						overflow = 1'b1;
					end
				end
				CMD_DELETE: begin
					if (lookup.hit) begin
						valid_d[wr_idx] = 1'b0;
						count_d         = count_q - lsd_cnt_t'(1);
					end
				end
				CMD_QUERY, CMD_RESERVED: begin
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else begin
			valid_q <= valid_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_we) begin
			state_q[wr_idx] <= new_state;
		end
		if (loc_we) begin
			loc_q[wr_idx] <= loc;
		end
	end

	assign entry_valid  = valid_q;
	assign entry_loc    = loc_q;
	assign entry_state  = state_q;
	assign upd.overflow = overflow;
	assign upd.count    = count_d;

endmodule

FILE: hdl/line_state_directory_table_unit.sv
// Pipeline: a word accepted into the input register yields its result word in the result register.
// Throughput: one word per cycle while the result register is not stalled; the sixteen-way parallel
// compare and update are combinational between the input register and the result register.
// Reset: arst_n clears all valid bits, the occupancy count and both handshake stages;
// stored locations and states are left as they are and are never read before written.
module line_state_directory_table_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          command,
	input  lsd_pkg::lsd_loc_t   location,
	input  lsd_pkg::lsd_state_t new_state,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                hit,
	output lsd_pkg::lsd_state_t state_out,
	output lsd_pkg::lsd_occ_t   occupancy,
	output logic                overflow
);
	import lsd_pkg::*;

	`include "line_state_directory_table_unit_macros.svh"

	// Input register: one command word waiting to be applied to the table.
	logic       valid_s1;
	lsd_cmd_t   cmd_s1;
	lsd_loc_t   loc_s1;
	lsd_state_t st_s1;

	// Result register.
	logic       out_valid_q;
	logic       hit_q;
	lsd_state_t state_q;
	lsd_occ_t   occ_q;
	logic       overflow_q;

	logic                           out_free;
	logic                           step;
	lsd_lookup_t                    lookup;
	lsd_upd_t                       upd;
	logic [Entries-1:0]             entry_valid;
	logic [Entries-1:0][LocW-1:0]   entry_loc;
	logic [Entries-1:0][StateW-1:0] entry_state;

	// The result register can take a new word when it is empty or being drained.
	// The command in the input register is applied to the table in exactly the
	// cycle it moves on, so the next command always sees the updated table.
	assign out_free = !out_valid_q || !out_stall;
	assign step     = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			cmd_s1 <= lsd_cmd_t'(command);
			loc_s1 <= location;
			st_s1  <= new_state;
		end
	end

	lsd_lookup u_lookup (
		.entry_valid (entry_valid),
		.entry_loc   (entry_loc),
		.entry_state (entry_state),
		.loc         (loc_s1),
		.result      (lookup)
	);

	lsd_store u_store (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.cmd         (cmd_s1),
		.loc         (loc_s1),
		.new_state   (st_s1),
		.lookup      (lookup),
		.entry_valid (entry_valid),
		.entry_loc   (entry_loc),
		.entry_state (entry_state),
		.upd         (upd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	// A miss reports state zero: the lookup leaves old_state clear then.
	always_ff @(posedge clk) begin
		if (step) begin
			hit_q      <= lookup.hit;
			state_q    <= lookup.old_state;
			occ_q      <= lsd_occ_t'(upd.count);
			overflow_q <= upd.overflow;
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = hit_q;
	assign state_out = state_q;
	assign occupancy = occ_q;
	assign overflow  = overflow_q;

	// A dropped insert only happens for an absent location into a full table.
	`LSD_ASSERT_SAME(a_ovf_miss, out_valid_q && overflow_q, !hit_q, "overflow with hit")
	`LSD_ASSERT_SAME(a_ovf_full, out_valid_q && overflow_q, occ_q == lsd_occ_t'(Entries), "overflow below full")
	`LSD_ASSERT_SAME(a_miss_zero, out_valid_q && !hit_q, state_q == '0, "miss with nonzero state")
	`LSD_ASSERT_SAME(a_occ_range, out_valid_q, occ_q <= lsd_occ_t'(Entries), "occupancy above table size")
	`LSD_ASSERT_NEXT(a_step_result, step, out_valid_q, "applied command lost its result")

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

// Self-checking bench for the line state directory table. A mirror of the
// sixteen-entry table predicts the reply to every accepted command word, and
// each reply word leaving the block is compared with the oldest prediction.
module tb_top;
	import lsd_pkg::*;

	// Each command word yields exactly one reply word.
	typedef struct packed {
		logic       hit;
		lsd_state_t state;
		lsd_occ_t   occ;
		logic       ovf;
	} reply_t;

	// Mirror of the directory. It is updated in the order that command
	// words are accepted, so the replies it queues up come out in the same
	// order as the block's reply words.
	class line_state_mirror;
		bit          present [Entries];
		lsd_loc_t    line_loc [Entries];
		lsd_state_t  line_state [Entries];
		int unsigned live_lines;
		reply_t      awaited [$];
		int unsigned mismatches;

		function void note_command(lsd_cmd_t cmd, lsd_loc_t loc, lsd_state_t st);
			int     found = -1;
			int     vacant = -1;
			reply_t r;
			for (int i = 0; i < Entries; i++) begin
				if (found < 0 && present[i] && line_loc[i] == loc)
					found = i;
				if (vacant < 0 && !present[i])
					vacant = i;
			end
			r.hit   = (found >= 0);
			r.state = (found >= 0) ? line_state[found] : '0;
			r.ovf   = 1'b0;
			case (cmd)
				CMD_INSERT: begin
					if (found >= 0) begin
						line_state[found] = st;
					end else if (vacant >= 0) begin
						present[vacant]    = 1'b1;
						line_loc[vacant]   = loc;
						line_state[vacant] = st;
						live_lines++;
					end else begin
						r.ovf = 1'b1;
					end
				end
				CMD_DELETE: begin
					if (found >= 0) begin
						present[found] = 1'b0;
						live_lines--;
					end
				end
				default: ;
			endcase
			r.occ = live_lines[OccW-1:0];
			awaited.push_back(r);
		endfunction

		function void check_reply(logic hit, lsd_state_t st, lsd_occ_t occ, logic ovf);
			reply_t want;
			if (awaited.size() == 0) begin
				$error("reply word with no command outstanding");
				mismatches++;
				return;
			end
			want = awaited.pop_front();
			if (hit !== want.hit) begin
				$error("hit: expected %0d, got %0d", want.hit, hit);
				mismatches++;
			end
			if (st !== want.state) begin
				$error("state_out: expected %0d, got %0d", want.state, st);
				mismatches++;
			end
			if (occ !== want.occ) begin
				$error("occupancy: expected %0d, got %0d", want.occ, occ);
				mismatches++;
			end
			if (ovf !== want.ovf) begin
				$error("overflow: expected %0d, got %0d", want.ovf, ovf);
				mismatches++;
			end
		endfunction
	endclass

	localparam int NumWords  = 1500;
	localparam int PoolSize  = 24;   // more than Entries, so inserts can overflow
	localparam int IdleLimit = 2000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [1:0] command = CMD_QUERY;
	lsd_loc_t   location = '0;
	lsd_state_t new_state = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       hit;
	lsd_state_t state_out;
	lsd_occ_t   occupancy;
	logic       overflow;

	line_state_mirror sb = new;

	// While calm is set neither side inserts idle cycles.
	bit calm = 1'b0;
	int idle_cycles = 0;
	lsd_loc_t line_pool [PoolSize];

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	line_state_directory_table_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.location  (location),
		.new_state (new_state),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.hit       (hit),
		.state_out (state_out),
		.occupancy (occupancy),
		.overflow  (overflow)
	);

	// The reply side stalls with a probability of roughly 18 percent, except
	// during the calm stretch.
	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(99) < 18);
	end

	// Both handshakes are sampled here. All block outputs and bench inputs
	// change by nonblocking assignment, so what is read at the edge is the
	// value from before it. The command word is noted before the reply is
	// checked, which keeps the order right even if a reply appears at the
	// same edge as its own command.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_command(lsd_cmd_t'(command), location, new_state);
			if (out_valid && !out_stall)
				sb.check_reply(hit, state_out, occupancy, overflow);
			// The watchdog only counts cycles in which neither side moves
			// a word, so a stuck handshake ends the run.
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IdleLimit) begin
				$display("tb_top NOT OK");
				$finish;
			end
		end
	end

	// Offers one command word and returns at the edge where it is taken.
	// Idle cycles are inserted in front of the word at random.
	task automatic issue(lsd_cmd_t cmd, lsd_loc_t loc, lsd_state_t st);
		while (!calm && $urandom_range(99) < 18) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		command   <= cmd;
		location  <= loc;
		new_state <= st;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	initial begin
		int       sent;
		int       mode;
		int       span;
		int       pick;
		lsd_cmd_t cmd;
		lsd_loc_t loc;

		// The pool mixes unrelated addresses with ones that differ from a
		// neighbor in a single bit, so a partial address compare would
		// show up as a false hit. Both extreme addresses are in it too.
		for (int i = 0; i < PoolSize; i++) begin
			if (i % 4 == 3)
				line_pool[i] = line_pool[i-1] ^ (32'd1 << $urandom_range(31));
			else
				line_pool[i] = $urandom;
		end
		line_pool[0] = '0;
		line_pool[1] = '1;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening on the empty table: misses on query and delete,
		// both address extremes, an update of a present line, the reserved
		// command acting as a query, the largest state code stored as given,
		// and a delete followed by a query that must miss.
		issue(CMD_QUERY, 32'h0000_0000, 3'd0);
		issue(CMD_DELETE, 32'h0000_0000, 3'd0);
		issue(CMD_INSERT, 32'h0000_0000, 3'd0);
		issue(CMD_INSERT, 32'hFFFF_FFFF, 3'd7);
		issue(CMD_QUERY, 32'hFFFF_FFFF, 3'd0);
		issue(CMD_INSERT, 32'h0000_0000, 3'd4);
		issue(CMD_QUERY, 32'h0000_0000, 3'd0);
		issue(CMD_RESERVED, 32'h0000_0000, 3'd6);
		issue(CMD_QUERY, 32'h0000_0001, 3'd0);
		issue(CMD_INSERT, 32'hA5A5_A5A5, 3'd1);
		issue(CMD_INSERT, 32'h5A5A_5A5A, 3'd2);
		issue(CMD_INSERT, 32'h8000_0000, 3'd3);
		issue(CMD_INSERT, 32'h0000_0001, 3'd5);
		issue(CMD_INSERT, 32'h8000_0000, 3'd6);
		issue(CMD_QUERY, 32'h8000_0000, 3'd0);
		issue(CMD_DELETE, 32'hFFFF_FFFF, 3'd0);
		issue(CMD_QUERY, 32'hFFFF_FFFF, 3'd0);
		issue(CMD_DELETE, 32'hFFFF_FFFE, 3'd0);
		issue(CMD_DELETE, 32'hA5A5_A5A5, 3'd0);
		issue(CMD_INSERT, 32'hFFFF_FFFF, 3'd3);

		// Random part in phases. A fill phase pushes the table to full so
		// that inserts of new lines are dropped, a drain phase empties it
		// again, and a mixed phase churns around the middle. Inserts only
		// use pool addresses so the table never clogs with lines that are
		// never seen again; lookups also use fresh random addresses, which
		// walk every address bit through both values.
		sent = 0;
		mode = 0;
		while (sent < NumWords) begin
			span = $urandom_range(40, 120);
			for (int k = 0; k < span && sent < NumWords; k++) begin
				calm = (sent >= 600 && sent < 900);
				pick = $urandom_range(99);
				case (mode)
					0: cmd = (pick < 70) ? CMD_INSERT : (pick < 80) ? CMD_DELETE :
						(pick < 95) ? CMD_QUERY : CMD_RESERVED;
					1: cmd = (pick < 10) ? CMD_INSERT : (pick < 80) ? CMD_DELETE :
						(pick < 95) ? CMD_QUERY : CMD_RESERVED;
					default: cmd = (pick < 35) ? CMD_INSERT : (pick < 65) ? CMD_DELETE :
						(pick < 95) ? CMD_QUERY : CMD_RESERVED;
				endcase
				if (cmd != CMD_INSERT && $urandom_range(99) < 20)
					loc = $urandom;
				else
					loc = line_pool[$urandom_range(PoolSize - 1)];
				issue(cmd, loc, lsd_state_t'($urandom_range(7)));
				sent++;
			end
			mode = $urandom_range(2);
		end
		in_valid <= 1'b0;
		calm = 1'b0;

		// Drain the outstanding replies, then keep clocking the two-stage pipe
		// so that it can show any reply word that should not be there.
		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);

		if (sb.mismatches == 0 && sb.awaited.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
